[hdl/rns_pkg.sv]
`default_nettype none

package rns_pkg;

    localparam int RESERVOIR_DEPTH = 64;
    localparam int COUNT_WIDTH     = 32;
    localparam int DATA_W          = 64;
    localparam int FANOUT_W        = 7;
    localparam int SEEN_W          = 32;
    localparam int IDX_W           = (RESERVOIR_DEPTH > 1) ? $clog2(RESERVOIR_DEPTH) : 1;
    localparam int HELD_W          = $clog2(RESERVOIR_DEPTH + 1);
    localparam int STEP_W          = $clog2(DATA_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIVIDE,
        ST_FLUSH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic append;
        logic drop;
        logic div_start;
        logic write_j;
        logic flush_rd;
        logic clear;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic fan_zero;
        logic held_lt_depth;
        logic held_lt_k;
        logic div_done;
        logic run_end;
        logic flush_last;
    } t_sts;

    function automatic logic [SEEN_W-1:0] sat_seen(input logic [COUNT_WIDTH-1:0] c);
        logic [63:0] w;
        w = 64'(c);
        if (w > 64'hFFFF_FFFF) begin
            return '1;
        end
        return w[SEEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/rns_div.sv]
`default_nettype none

module rns_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [rns_pkg::DATA_W-1:0]       i_dividend,
    input  wire logic [rns_pkg::COUNT_WIDTH-1:0]  i_divisor,
    output logic                                  o_done,
    output logic [rns_pkg::COUNT_WIDTH-1:0]       o_rem
);
    import rns_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [STEP_W-1:0]      r_cnt;
    logic [DATA_W-1:0]      r_dvd;
    logic [COUNT_WIDTH-1:0] r_rem;
    logic [COUNT_WIDTH-1:0] r_dsr;

    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   diff;
    logic [COUNT_WIDTH-1:0] n_rem;
    logic                   last_step;

    // one restoring step per cycle, dividend bits enter MSB first
    always_comb begin
        trial     = {r_rem, r_dvd[DATA_W-1]};
        diff      = trial - {1'b0, r_dsr};
        n_rem     = (trial >= {1'b0, r_dsr}) ? diff[COUNT_WIDTH-1:0]
                                             : trial[COUNT_WIDTH-1:0];
        last_step = (r_cnt == STEP_W'(DATA_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + STEP_W'(1);
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DATA_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[hdl/rns_ctrl.sv]
`default_nettype none

module rns_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire rns_pkg::t_sts i_sts,
    output rns_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import rns_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!i_sts.fan_zero && !i_sts.held_lt_k) begin
                    n_state = ST_DIVIDE;
                end else if (i_sts.run_end) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIVIDE: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.run_end ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (i_sts.flush_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_start;
            end
            ST_EVAL: begin
                if (i_sts.fan_zero) begin
                    o_cmd.append = i_sts.held_lt_depth;
                    o_cmd.drop   = !i_sts.held_lt_depth;
                end else begin
                    o_cmd.append    = i_sts.held_lt_k;
                    o_cmd.div_start = !i_sts.held_lt_k;
                end
            end
            ST_DIVIDE: begin
                o_cmd.write_j = i_sts.div_done;
            end
            ST_FLUSH: begin
                o_cmd.flush_rd = 1'b1;
                o_cmd.clear    = i_sts.flush_last;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/rns_dpath.sv]
`default_nettype none

module rns_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [rns_pkg::FANOUT_W-1:0]  i_cfg_wdata,
    input  wire logic [rns_pkg::DATA_W-1:0]    i_source_node,
    input  wire logic [rns_pkg::DATA_W-1:0]    i_neighbor_id,
    input  wire logic [rns_pkg::DATA_W-1:0]    i_edge_ident,
    input  wire logic [rns_pkg::DATA_W-1:0]    i_random_word,
    input  wire logic                          i_run_end,
    input  wire rns_pkg::t_cmd                 i_cmd,
    output rns_pkg::t_sts                      o_sts,
    output logic                               o_strobe,
    output logic [rns_pkg::DATA_W-1:0]         o_out_source,
    output logic [rns_pkg::DATA_W-1:0]         o_out_neighbor,
    output logic [rns_pkg::DATA_W-1:0]         o_out_edge,
    output logic [rns_pkg::SEEN_W-1:0]         o_edges_seen,
    output logic                               o_truncated,
    output logic                               o_last_sample
);
    import rns_pkg::*;

    localparam logic [FANOUT_W-1:0] DEPTH_F = FANOUT_W'(RESERVOIR_DEPTH);

    logic [2*DATA_W-1:0]    mem [RESERVOIR_DEPTH];

    logic [FANOUT_W-1:0]    r_fanout;
    logic [HELD_W-1:0]      r_held;
    logic [COUNT_WIDTH-1:0] r_seen;
    logic                   r_dropped;
    logic [IDX_W-1:0]       r_idx;
    logic [DATA_W-1:0]      r_src;
    logic [DATA_W-1:0]      r_nb;
    logic [DATA_W-1:0]      r_ed;
    logic [DATA_W-1:0]      r_rnd;
    logic                   r_end;
    logic                   r_strobe;
    logic                   r_last;
    logic [2*DATA_W-1:0]    r_rd;
    logic [SEEN_W-1:0]      r_out_seen;
    logic                   r_out_trunc;

    logic [FANOUT_W-1:0]    cap;
    logic                   div_done;
    logic [COUNT_WIDTH-1:0] div_rem;
    logic                   j_lt_k;
    logic                   wen;
    logic [IDX_W-1:0]       waddr;
    logic                   flush_last;

    rns_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_seen),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_comb begin
        cap        = (r_fanout > DEPTH_F) ? DEPTH_F : r_fanout;
        j_lt_k     = (div_rem < COUNT_WIDTH'(cap));
        wen        = i_cmd.append || (i_cmd.write_j && j_lt_k);
        waddr      = i_cmd.append ? r_held[IDX_W-1:0] : div_rem[IDX_W-1:0];
        flush_last = (r_held == (HELD_W'(r_idx) + HELD_W'(1)));

        o_sts.fan_zero      = (r_fanout == '0);
        o_sts.held_lt_depth = (r_held < HELD_W'(RESERVOIR_DEPTH));
        o_sts.held_lt_k     = (FANOUT_W'(r_held) < cap);
        o_sts.div_done      = div_done;
        o_sts.run_end       = r_end;
        o_sts.flush_last    = flush_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fanout  <= '0;
            r_held    <= '0;
            r_seen    <= '0;
            r_dropped <= 1'b0;
            r_idx     <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= i_cmd.flush_rd;
            if (i_cfg_we) begin
                r_fanout <= i_cfg_wdata;
            end
            if (i_cmd.accept && (r_seen != '1)) begin
                r_seen <= r_seen + COUNT_WIDTH'(1);
            end
            if (i_cmd.append) begin
                r_held <= r_held + HELD_W'(1);
            end
            if (i_cmd.drop) begin
                r_dropped <= 1'b1;
            end
            if (i_cmd.flush_rd && !i_cmd.clear) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.clear) begin
                r_held    <= '0;
                r_seen    <= '0;
                r_dropped <= 1'b0;
                r_idx     <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_src <= i_source_node;
            r_nb  <= i_neighbor_id;
            r_ed  <= i_edge_ident;
            r_rnd <= i_random_word;
            r_end <= i_run_end;
        end
        if (i_cmd.flush_rd) begin
            r_last      <= flush_last;
            r_out_seen  <= sat_seen(r_seen);
            r_out_trunc <= r_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            mem[waddr] <= {r_nb, r_ed};
        end
        if (i_cmd.flush_rd) begin
            r_rd <= mem[r_idx];
        end
    end

    assign o_strobe       = r_strobe;
    assign o_out_source   = r_src;
    assign o_out_neighbor = r_rd[2*DATA_W-1:DATA_W];
    assign o_out_edge     = r_rd[DATA_W-1:0];
    assign o_edges_seen   = r_out_seen;
    assign o_truncated    = r_out_trunc;
    assign o_last_sample  = r_last;

endmodule

`default_nettype wire

[hdl/reservoir_neighbor_sampler_unit.sv]
// Reservoir neighbor sampler: keeps a uniform sample of one node's edges.
//
// Input channel: the caller presents one edge word (source node, neighbor,
// edge id, random word, run_end) and raises start; the word is taken at the
// rising edge where start is high and busy is low.
// Output channel: each sample leaves as one word, shown for exactly one cycle
// with o_strobe high; the receiver cannot stall, it must take it then.
// Config: i_cfg_we writes the fanout cap (0 = keep everything up to the
// reservoir depth); write only while busy is low.
// An appended or dropped edge holds busy high only in the evaluate state.
// An edge that goes to replacement runs the 64-bit remainder unit, one bit
// per cycle, and busy stays high until it is done; the sample memory write,
// made only if the remainder is below the cap, happens as the division ends.
// A run_end edge then streams its held samples back to back, one per cycle,
// starting in the cycle after the flush begins (memory read is registered);
// the final word carries o_last_sample and a new edge can be taken then.
// Reset (synchronous, active low) empties the reservoir, zeroes the edge
// count and the truncation flag and sets the fanout to 0. Memory contents
// are not cleared: only slots below the held count are ever read.
`default_nettype none

module reservoir_neighbor_sampler_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cfg_we,
    input  wire logic [rns_pkg::FANOUT_W-1:0]  i_cfg_wdata,
    input  wire logic [rns_pkg::DATA_W-1:0]    i_source_node,
    input  wire logic [rns_pkg::DATA_W-1:0]    i_neighbor_id,
    input  wire logic [rns_pkg::DATA_W-1:0]    i_edge_ident,
    input  wire logic [rns_pkg::DATA_W-1:0]    i_random_word,
    input  wire logic                          i_run_end,
    output logic                               o_strobe,
    output logic [rns_pkg::DATA_W-1:0]         o_out_source,
    output logic [rns_pkg::DATA_W-1:0]         o_out_neighbor,
    output logic [rns_pkg::DATA_W-1:0]         o_out_edge,
    output logic [rns_pkg::SEEN_W-1:0]         o_edges_seen,
    output logic                               o_truncated,
    output logic                               o_last_sample
);
    import rns_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing: accept, decide append/drop/replace, wait on remainder, flush
    rns_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // holds the reservoir memory, counters, remainder unit and output word
    rns_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_source_node  (i_source_node),
        .i_neighbor_id  (i_neighbor_id),
        .i_edge_ident   (i_edge_ident),
        .i_random_word  (i_random_word),
        .i_run_end      (i_run_end),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_strobe       (o_strobe),
        .o_out_source   (o_out_source),
        .o_out_neighbor (o_out_neighbor),
        .o_out_edge     (o_out_edge),
        .o_edges_seen   (o_edges_seen),
        .o_truncated    (o_truncated),
        .o_last_sample  (o_last_sample)
    );

endmodule

`default_nettype wire

[hdl/rns_chk.sv]
`default_nettype none

module rns_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_strobe,
    input wire logic [rns_pkg::DATA_W-1:0]    o_out_source,
    input wire logic [rns_pkg::SEEN_W-1:0]    o_edges_seen,
    input wire logic                          o_last_sample
);
    // an accepted word makes the block busy in the cycle after it is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after accept");

    // no word can leave in the cycle right after an accept
    a_no_word_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("output word right after accept");

    // a flush streams without gaps until its last word
    a_flush_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_sample) |=> o_strobe)
        else $error("gap inside a flush");

    // no new edge is taken while a flush is still in progress
    a_busy_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_sample) |-> busy)
        else $error("not busy during a flush");

    // node id and count stay fixed across one flush
    a_run_fields_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_sample) |=> ($stable(o_out_source) && $stable(o_edges_seen)))
        else $error("run fields changed within a flush");

endmodule

bind reservoir_neighbor_sampler_unit rns_chk u_rns_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_out_source  (o_out_source),
    .o_edges_seen  (o_edges_seen),
    .o_last_sample (o_last_sample)
);

`default_nettype wire

[tb/rns_sample_checker.sv]
`timescale 1ns / 1ps

module rns_sample_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic                            i_busy,
    input  wire logic                            i_cfg_we,
    input  wire logic [rns_pkg::FANOUT_W-1:0]    i_cfg_wdata,
    input  wire logic [rns_pkg::DATA_W-1:0]      i_source_node,
    input  wire logic [rns_pkg::DATA_W-1:0]      i_neighbor_id,
    input  wire logic [rns_pkg::DATA_W-1:0]      i_edge_ident,
    input  wire logic [rns_pkg::DATA_W-1:0]      i_random_word,
    input  wire logic                            i_run_end,
    input  wire logic                            i_strobe,
    input  wire logic [rns_pkg::DATA_W-1:0]      i_out_source,
    input  wire logic [rns_pkg::DATA_W-1:0]      i_out_neighbor,
    input  wire logic [rns_pkg::DATA_W-1:0]      i_out_edge,
    input  wire logic [rns_pkg::SEEN_W-1:0]      i_edges_seen,
    input  wire logic                            i_truncated,
    input  wire logic                            i_last_sample,
    output int                                   o_error_count,
    output int                                   o_pending
);
    import rns_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] source;
        logic [DATA_W-1:0] neighbor;
        logic [DATA_W-1:0] edge_id;
        logic [SEEN_W-1:0] seen;
        logic              trunc;
        logic              last;
    } t_sample_word;

    t_sample_word           expected_samples[$];
    t_sample_word           oldest;
    logic [DATA_W-1:0]      kept_neighbor[RESERVOIR_DEPTH];
    logic [DATA_W-1:0]      kept_edge[RESERVOIR_DEPTH];
    logic [HELD_W-1:0]      held_samples;
    logic [COUNT_WIDTH-1:0] edge_count;
    logic                   overflowed;
    logic [FANOUT_W-1:0]    fanout_cap;
    int                     errors = 0;

    task automatic keep(int slot);
        kept_neighbor[slot] = i_neighbor_id;
        kept_edge[slot]     = i_edge_ident;
    endtask

    task automatic compare(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Sample one accepted edge word; on run_end, queue the flush.
    task automatic sample_edge();
        int                cap;
        logic [63:0]       slot;
        logic [SEEN_W-1:0] seen_out;
        t_sample_word      w;
        if (edge_count != '1) begin
            edge_count = edge_count + COUNT_WIDTH'(1);
        end
        if (fanout_cap == '0) begin
            if (held_samples < RESERVOIR_DEPTH) begin
                keep(int'(held_samples));
                held_samples = held_samples + HELD_W'(1);
            end else begin
                overflowed = 1'b1;
            end
        end else begin
            cap = (fanout_cap > RESERVOIR_DEPTH) ? RESERVOIR_DEPTH : int'(fanout_cap);
            if (held_samples < cap) begin
                keep(int'(held_samples));
                held_samples = held_samples + HELD_W'(1);
            end else begin
                slot = i_random_word % 64'(edge_count);
                if (slot < 64'(cap)) begin
                    keep(int'(slot));
                end
            end
        end
        if (i_run_end) begin
            seen_out = (64'(edge_count) > 64'hFFFF_FFFF) ? '1 : edge_count[SEEN_W-1:0];
            for (int i = 0; i < held_samples; i++) begin
                w.source   = i_source_node;
                w.neighbor = kept_neighbor[i];
                w.edge_id  = kept_edge[i];
                w.seen     = seen_out;
                w.trunc    = overflowed;
                w.last     = (i + 1 == held_samples);
                expected_samples.insert(expected_samples.size(), w);
            end
            held_samples = '0;
            edge_count   = '0;
            overflowed   = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_samples = '0;
            edge_count   = '0;
            overflowed   = 1'b0;
            fanout_cap   = '0;
            expected_samples.delete();
        end else begin
            if (i_strobe) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected sample word: expected none, got %h/%h",
                             $time, i_out_neighbor, i_out_edge);
                    errors++;
                end else begin
                    oldest = expected_samples.pop_front();
                    compare("out_source",   oldest.source,   i_out_source);
                    compare("out_neighbor", oldest.neighbor, i_out_neighbor);
                    compare("out_edge",     oldest.edge_id,  i_out_edge);
                    compare("edges_seen",   64'(oldest.seen), 64'(i_edges_seen));
                    compare("truncated",    64'(oldest.trunc), 64'(i_truncated));
                    compare("last_sample",  64'(oldest.last), 64'(i_last_sample));
                end
            end
            if (i_cfg_we) begin
                fanout_cap = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                sample_edge();
            end
        end
        o_pending     <= expected_samples.size();
        o_error_count <= errors;
    end

endmodule

[tb/tb_reservoir_neighbor_sampler_unit.sv]
`timescale 1ns / 1ps

module tb_reservoir_neighbor_sampler_unit;
    import rns_pkg::*;

    // Cycles to hold after the last sample word: covers a full remainder
    // pass of an edge that produces no word.
    localparam int SETTLE_CYCLES = 80;
    // Cycles with no word moving on either side before the run is aborted.
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 320;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_cfg_we;
    logic [FANOUT_W-1:0] i_cfg_wdata;
    logic [DATA_W-1:0]   i_source_node;
    logic [DATA_W-1:0]   i_neighbor_id;
    logic [DATA_W-1:0]   i_edge_ident;
    logic [DATA_W-1:0]   i_random_word;
    logic                i_run_end;
    logic                o_strobe;
    logic [DATA_W-1:0]   o_out_source;
    logic [DATA_W-1:0]   o_out_neighbor;
    logic [DATA_W-1:0]   o_out_edge;
    logic [SEEN_W-1:0]   o_edges_seen;
    logic                o_truncated;
    logic                o_last_sample;

    int error_count;
    int pending_words;
    int quiet_cycles = 0;
    int edges_sent   = 0;
    bit gaps_on      = 1'b1;

    always #1 i_clk = ~i_clk;

    reservoir_neighbor_sampler_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_source_node  (i_source_node),
        .i_neighbor_id  (i_neighbor_id),
        .i_edge_ident   (i_edge_ident),
        .i_random_word  (i_random_word),
        .i_run_end      (i_run_end),
        .o_strobe       (o_strobe),
        .o_out_source   (o_out_source),
        .o_out_neighbor (o_out_neighbor),
        .o_out_edge     (o_out_edge),
        .o_edges_seen   (o_edges_seen),
        .o_truncated    (o_truncated),
        .o_last_sample  (o_last_sample)
    );

    // The checker predicts every sample word and compares it; this module
    // only drives stimulus and reports the verdict.
    rns_sample_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_source_node  (i_source_node),
        .i_neighbor_id  (i_neighbor_id),
        .i_edge_ident   (i_edge_ident),
        .i_random_word  (i_random_word),
        .i_run_end      (i_run_end),
        .i_strobe       (o_strobe),
        .i_out_source   (o_out_source),
        .i_out_neighbor (o_out_neighbor),
        .i_out_edge     (o_out_edge),
        .i_edges_seen   (o_edges_seen),
        .i_truncated    (o_truncated),
        .i_last_sample  (o_last_sample),
        .o_error_count  (error_count),
        .o_pending      (pending_words)
    );

    // Watchdog: count cycles in which no edge word is taken and no sample
    // word comes out; abort when the count runs past the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_reservoir_neighbor_sampler_unit: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Bias the random word toward small values and all-ones so that the
    // replacement slot often lands below the cap, and sometimes just above.
    function automatic logic [63:0] pick_random_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return rand64();
        end
        if (roll < 80) begin
            return 64'($urandom_range(0, 7));
        end
        if (roll < 88) begin
            return '1;
        end
        return rand64() & 64'hFF;
    endfunction

    function automatic logic [FANOUT_W-1:0] pick_fanout();
        case ($urandom_range(0, 5))
            0: begin
                return '0;
            end
            1: begin
                return FANOUT_W'($urandom_range(1, 3));
            end
            2: begin
                return FANOUT_W'($urandom_range(4, 12));
            end
            3: begin
                return FANOUT_W'($urandom_range(60, 64));
            end
            4: begin
                return FANOUT_W'($urandom_range(65, 127));
            end
            default: begin
                return FANOUT_W'($urandom_range(0, 127));
            end
        endcase
    endfunction

    // Mostly short runs; now and then a run long enough to overflow the
    // store in unlimited mode, or to reach replacement with the cap at depth.
    function automatic int pick_run_length(logic [FANOUT_W-1:0] cap);
        int roll;
        roll = $urandom_range(0, 99);
        if (cap == '0 && roll < 12) begin
            return $urandom_range(64, 72);
        end
        if (cap >= RESERVOIR_DEPTH && roll < 12) begin
            return $urandom_range(65, 68);
        end
        if (roll < 20) begin
            return 1;
        end
        return $urandom_range(2, 14);
    endfunction

    // Present one edge word and hold it until the block takes it. Return
    // on the accepting edge with start still high, so the next call either
    // keeps it high or drops it, never both in one step.
    task automatic send_edge(logic [63:0] src, logic [63:0] nb, logic [63:0] ed,
                             logic [63:0] rnd, logic last);
        int gap;
        if (gaps_on && $urandom_range(0, 99) < 30) begin
            start <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge i_clk);
        end
        i_source_node <= src;
        i_neighbor_id <= nb;
        i_edge_ident  <= ed;
        i_random_word <= rnd;
        i_run_end     <= last;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        edges_sent++;
    endtask

    // Drop start, drain every sample word, let a remainder pass finish,
    // then write the fanout cap.
    task automatic set_fanout(logic [FANOUT_W-1:0] cap);
        start <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One node's edges; with mixed set, some edges carry a stray source id.
    task automatic send_run(int len, bit mixed);
        logic [63:0] node;
        logic [63:0] src;
        node = rand64();
        for (int i = 0; i < len; i++) begin
            src = (mixed && $urandom_range(0, 9) == 0) ? rand64() : node;
            send_edge(src, rand64(), rand64(), pick_random_word(), i == len - 1);
        end
    endtask

    initial begin
        logic [FANOUT_W-1:0] cap;
        int                  runs;
        int                  phase;

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        i_source_node <= '0;
        i_neighbor_id <= '0;
        i_edge_ident  <= '0;
        i_random_word <= '0;
        i_run_end     <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unlimited mode out of reset: field extremes, all zeros and all ones.
        send_edge('0, '0, '0, '0, 1'b0);
        send_edge('1, '1, '1, '1, 1'b0);
        send_edge('1, '0, '1, '0, 1'b1);
        // Single-edge run, alternating bit patterns.
        send_edge({4{16'hAAAA}}, {4{16'h5555}}, {4{16'hAAAA}}, {4{16'h5555}}, 1'b1);

        // Cap of two: slot 0 replaced, a miss, then all-ones mod 5 hits slot 0.
        set_fanout(7'd2);
        send_edge(64'd7, rand64(), rand64(), rand64(), 1'b0);
        send_edge(64'd7, rand64(), rand64(), rand64(), 1'b0);
        send_edge(64'd7, rand64(), rand64(), 64'd0, 1'b0);
        send_edge(64'd7, rand64(), rand64(), 64'd3, 1'b0);
        send_edge(64'd7, rand64(), rand64(), '1, 1'b1);

        // Cap lowered mid-run below what is held: replace only into slots
        // under the new cap, and still flush all four held samples.
        set_fanout(7'd4);
        for (int i = 0; i < 5; i++) begin
            send_edge(64'd9, rand64(), rand64(), 64'(i == 4), 1'b0);
        end
        set_fanout(7'd1);
        send_edge(64'd9, rand64(), rand64(), 64'd0, 1'b0);
        send_edge(64'd9, rand64(), rand64(), 64'd3, 1'b1);

        // Random phases: the first ones walk the cap extremes and the
        // above-depth clamp, then caps are drawn at random.
        edges_sent = 0;
        phase      = 0;
        while (edges_sent < RANDOM_ITEMS) begin
            case (phase)
                0: cap = 7'd127;
                1: cap = 7'(RESERVOIR_DEPTH);
                2: cap = '0;
                3: cap = 7'd1;
                default: cap = pick_fanout();
            endcase
            set_fanout(cap);
            runs = $urandom_range(1, 4);
            repeat (runs) begin
                if (edges_sent < RANDOM_ITEMS) begin
                    send_run(pick_run_length(cap), 1'b1);
                    // Hold a long stretch with no sender gaps in the middle.
                    gaps_on = !(edges_sent >= 120 && edges_sent < 200);
                end
            end
            phase++;
        end

        // Drain, then watch a while longer for stray sample words.
        start <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_words == 0) begin
            $display("tb_reservoir_neighbor_sampler_unit: done, clean");
        end else begin
            $display("tb_reservoir_neighbor_sampler_unit: done, errors");
        end
        $finish;
    end

endmodule
